// ----- rtl/tkls_pkg.sv -----
package tkls_pkg;

  // List depth of the largest and smallest interval rows
  localparam int LIST_DEPTH = 8;

  localparam int WORD_W = 64;
  localparam int CNT_W  = 32;
  localparam int FUNC_W = 2;
  localparam int RANK_W = 3;

  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_DURATION = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STAMP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 2'd2;

  // What one cell hands to its right-hand neighbor
  typedef struct packed {
    logic              lg_before;
    logic [WORD_W-1:0] lg;
    logic              sm_before;
    logic [WORD_W-1:0] sm;
  } link_t;

endpackage

// ----- rtl/tkls_req_if.sv -----
interface tkls_req_if;
  logic                       valid;
  logic                       ready;
  logic [tkls_pkg::FUNC_W-1:0] func;
  logic [tkls_pkg::WORD_W-1:0] sample;
  logic [tkls_pkg::RANK_W-1:0] rank;

  modport source (output valid, func, sample, rank, input ready);
  modport sink   (input valid, func, sample, rank, output ready);
endinterface

// ----- rtl/tkls_rsp_if.sv -----
interface tkls_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [tkls_pkg::CNT_W-1:0]  hit_total;
  logic [tkls_pkg::WORD_W-1:0] sum_of_intervals;
  logic [tkls_pkg::WORD_W-1:0] largest_at_rank;
  logic [tkls_pkg::WORD_W-1:0] smallest_at_rank;
  logic                       interval_taken;

  modport source (output valid, hit_total, sum_of_intervals, largest_at_rank,
                  smallest_at_rank, interval_taken, input ready);
  modport sink   (input valid, hit_total, sum_of_intervals, largest_at_rank,
                  smallest_at_rank, interval_taken, output ready);
endinterface

// ----- rtl/tkls_cell.sv -----
module tkls_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [tkls_pkg::WORD_W-1:0] v,
  input  tkls_pkg::link_t             left,
  output tkls_pkg::link_t             right
);

  logic [tkls_pkg::WORD_W-1:0] lg;
  logic [tkls_pkg::WORD_W-1:0] sm;

  // Compare the new interval against this entry; equal values stay ahead
  assign right.lg_before = (v > lg);
  assign right.sm_before = (v < sm);
  assign right.lg        = lg;
  assign right.sm        = sm;

  // Shift in the neighbor's entry, or take the new value where it lands
  always_ff @(posedge clk) begin
    if (rst) begin
      lg <= '0;
      sm <= tkls_pkg::ALL_ONES;
    end else if (en) begin
      if (left.lg_before) begin
        lg <= left.lg;
      end else if (right.lg_before) begin
        lg <= v;
      end
      if (left.sm_before) begin
        sm <= left.sm;
      end else if (right.sm_before) begin
        sm <= v;
      end
    end
  end

endmodule

// ----- rtl/top_k_latency_statistics.sv -----
// Timing statistics for one timer channel. Each request word carries a
// duration, a timestamp or a read; a timestamp becomes the interval since
// the previous one (mod 2^64), and the first timestamp after reset or after
// an all-ones stamp gives no interval. The block keeps the LIST_DEPTH largest
// and smallest intervals in a row of cells, one entry of each list per cell,
// plus a wrapping interval total and sample count. Every request returns one
// response word with the count, the total and both list entries at the given
// rank, as they stand after the update. The request word is captured at the
// accepting edge and then passes through the interval subtract step, the
// parallel sorted insert across the cells and the rank readout step, which
// loads the response register. A new request is accepted once the previous
// one has reached the response register; while that response waits to be
// taken, the next request holds in its readout step.
module top_k_latency_statistics (
  input logic       clk,
  input logic       rst,
  tkls_req_if.sink  req,
  tkls_rsp_if.source rsp
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIFF = 2'd1;
  localparam logic [1:0] P_INS  = 2'd2;
  localparam logic [1:0] P_READ = 2'd3;

  logic [1:0]                  phase;
  logic [tkls_pkg::FUNC_W-1:0] func_q;
  logic [tkls_pkg::WORD_W-1:0] sample_q;
  logic [tkls_pkg::RANK_W-1:0] rank_q;
  logic [tkls_pkg::WORD_W-1:0] interval;
  logic                        take;
  logic [tkls_pkg::WORD_W-1:0] prev_stamp;
  logic [tkls_pkg::CNT_W-1:0]  hit_counter;
  logic [tkls_pkg::WORD_W-1:0] interval_sum;

  logic                        out_valid;
  logic [tkls_pkg::CNT_W-1:0]  out_hits;
  logic [tkls_pkg::WORD_W-1:0] out_sum;
  logic [tkls_pkg::WORD_W-1:0] out_lg;
  logic [tkls_pkg::WORD_W-1:0] out_sm;
  logic                        out_taken;

  logic                        load_out;
  logic                        cell_en;
  logic [tkls_pkg::WORD_W-1:0] rd_lg;
  logic [tkls_pkg::WORD_W-1:0] rd_sm;
  tkls_pkg::link_t             head;
  tkls_pkg::link_t             link [tkls_pkg::LIST_DEPTH];

  assign req.ready = (phase == P_IDLE);
  assign load_out  = (phase == P_READ) && (!out_valid || rsp.ready);
  assign cell_en   = (phase == P_INS) && take;

  assign rsp.valid            = out_valid;
  assign rsp.hit_total        = out_hits;
  assign rsp.sum_of_intervals = out_sum;
  assign rsp.largest_at_rank  = out_lg;
  assign rsp.smallest_at_rank = out_sm;
  assign rsp.interval_taken   = out_taken;

  // Sequence one request through capture, subtract, insert and readout
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= P_IDLE;
      out_valid    <= 1'b0;
      prev_stamp   <= tkls_pkg::ALL_ONES;
      hit_counter  <= '0;
      interval_sum <= '0;
    end else begin
      case (phase)
        P_IDLE: begin
          if (req.valid) begin
            phase <= P_DIFF;
          end
        end
        P_DIFF: begin
          if (func_q == tkls_pkg::FUNC_DURATION || func_q == tkls_pkg::FUNC_STAMP) begin
            hit_counter <= hit_counter + 1'b1;
          end
          if (func_q == tkls_pkg::FUNC_STAMP) begin
            prev_stamp <= sample_q;
          end
          phase <= P_INS;
        end
        P_INS: begin
          if (take) begin
            interval_sum <= interval_sum + interval;
          end
          phase <= P_READ;
        end
        P_READ: begin
          if (load_out) begin
            phase <= P_IDLE;
          end
        end
        default: phase <= P_IDLE;
      endcase

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the request word and form the interval
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      func_q   <= req.func;
      sample_q <= req.sample;
      rank_q   <= req.rank;
    end
    if (phase == P_DIFF) begin
      interval <= (func_q == tkls_pkg::FUNC_STAMP) ? sample_q - prev_stamp : sample_q;
      take     <= (func_q == tkls_pkg::FUNC_DURATION) ||
                  (func_q == tkls_pkg::FUNC_STAMP && prev_stamp != tkls_pkg::ALL_ONES);
    end
  end

  // Row of list cells, rank 0 on the left
  always_comb begin
    head           = '0;
    head.lg        = '0;
    head.sm        = tkls_pkg::ALL_ONES;
    head.lg_before = 1'b0;
    head.sm_before = 1'b0;
  end

  for (genvar i = 0; i < tkls_pkg::LIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      tkls_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .en    (cell_en),
        .v     (interval),
        .left  (head),
        .right (link[i])
      );
    end else begin : g_rest
      tkls_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .en    (cell_en),
        .v     (interval),
        .left  (link[i-1]),
        .right (link[i])
      );
    end
  end

  // Pick the entries at the requested rank; empty values beyond the depth
  always_comb begin
    rd_lg = '0;
    rd_sm = tkls_pkg::ALL_ONES;
    for (int i = 0; i < tkls_pkg::LIST_DEPTH; i++) begin
      if (int'(rank_q) == i) begin
        rd_lg = link[i].lg;
        rd_sm = link[i].sm;
      end
    end
  end

  // Hold the response word until it is taken
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hits  <= hit_counter;
      out_sum   <= interval_sum;
      out_lg    <= rd_lg;
      out_sm    <= rd_sm;
      out_taken <= take;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (phase == P_DIFF))
    else $error("accepted request did not start the subtract step");

  a_count_only_in_diff: assert property (@(posedge clk) disable iff (rst)
    (phase != P_DIFF) |=> $stable(hit_counter))
    else $error("hit counter moved outside the subtract step");

  a_sum_only_in_ins: assert property (@(posedge clk) disable iff (rst)
    (phase != P_INS) |=> $stable(interval_sum))
    else $error("interval total moved outside the insert step");

  a_rsp_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(phase) == P_READ))
    else $error("response appeared without a readout step");

  if (tkls_pkg::LIST_DEPTH > 1) begin : g_order_chk
    a_lists_sorted: assert property (@(posedge clk) disable iff (rst)
      (link[0].lg >= link[1].lg) && (link[0].sm <= link[1].sm))
      else $error("list head out of order");
  end

endmodule

// ----- tb/tkls_stats_checker.sv -----
`timescale 1ns / 100ps

module tkls_stats_checker (
  input  logic clk,
  input  logic rst,
  tkls_req_if  req,
  tkls_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);

  typedef logic [tkls_pkg::LIST_DEPTH-1:0][tkls_pkg::WORD_W-1:0] ranked_row_t;

  typedef struct packed {
    logic [tkls_pkg::CNT_W-1:0]  hit_total;
    logic [tkls_pkg::WORD_W-1:0] sum_of_intervals;
    logic [tkls_pkg::WORD_W-1:0] largest_at_rank;
    logic [tkls_pkg::WORD_W-1:0] smallest_at_rank;
    logic                        interval_taken;
  } stats_word_t;

  // Mirror of the statistics state
  ranked_row_t                 top_values;
  ranked_row_t                 bottom_values;
  logic [tkls_pkg::WORD_W-1:0] interval_total;
  logic [tkls_pkg::CNT_W-1:0]  sample_count;
  logic [tkls_pkg::WORD_W-1:0] last_stamp;

  stats_word_t expected_words[$];

  // Place v in a sorted row; equal entries stay ahead, the deepest entry drops
  function automatic ranked_row_t insert_ranked(ranked_row_t row,
                                                logic [tkls_pkg::WORD_W-1:0] v,
                                                bit descending);
    ranked_row_t res;
    int          slot;
    int          i;
    slot = tkls_pkg::LIST_DEPTH;
    for (i = tkls_pkg::LIST_DEPTH - 1; i >= 0; i--) begin
      if (descending ? (v > row[i]) : (v < row[i])) slot = i;
    end
    res = row;
    for (i = slot + 1; i < tkls_pkg::LIST_DEPTH; i++) res[i] = row[i-1];
    if (slot < tkls_pkg::LIST_DEPTH) res[slot] = v;
    return res;
  endfunction

  function automatic void absorb_interval(logic [tkls_pkg::WORD_W-1:0] v);
    top_values     = insert_ranked(top_values, v, 1'b1);
    bottom_values  = insert_ranked(bottom_values, v, 1'b0);
    interval_total = interval_total + v;
  endfunction

  always @(posedge clk) begin
    stats_word_t want;
    logic        took;
    if (rst) begin
      top_values     = '0;
      bottom_values  = {tkls_pkg::LIST_DEPTH{tkls_pkg::ALL_ONES}};
      interval_total = '0;
      sample_count   = '0;
      last_stamp     = tkls_pkg::ALL_ONES;
      fail_count     = 0;
      expected_words.delete();
    end else begin
      // Compare the delivered word with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (expected_words.size() == 0) begin
          $error("response word with nothing outstanding");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (rsp.hit_total !== want.hit_total) begin
            $error("hit_total expected %0d got %0d", want.hit_total, rsp.hit_total);
            fail_count++;
          end
          if (rsp.sum_of_intervals !== want.sum_of_intervals) begin
            $error("sum_of_intervals expected %h got %h",
                   want.sum_of_intervals, rsp.sum_of_intervals);
            fail_count++;
          end
          if (rsp.largest_at_rank !== want.largest_at_rank) begin
            $error("largest_at_rank expected %h got %h",
                   want.largest_at_rank, rsp.largest_at_rank);
            fail_count++;
          end
          if (rsp.smallest_at_rank !== want.smallest_at_rank) begin
            $error("smallest_at_rank expected %h got %h",
                   want.smallest_at_rank, rsp.smallest_at_rank);
            fail_count++;
          end
          if (rsp.interval_taken !== want.interval_taken) begin
            $error("interval_taken expected %0b got %0b",
                   want.interval_taken, rsp.interval_taken);
            fail_count++;
          end
        end
      end

      // Update the mirror for an accepted request word and queue its result
      if (req.valid && req.ready) begin
        took = 1'b0;
        if (req.func == tkls_pkg::FUNC_DURATION) begin
          absorb_interval(req.sample);
          sample_count++;
          took = 1'b1;
        end else if (req.func == tkls_pkg::FUNC_STAMP) begin
          if (last_stamp != tkls_pkg::ALL_ONES) begin
            absorb_interval(req.sample - last_stamp);
            took = 1'b1;
          end
          last_stamp = req.sample;
          sample_count++;
        end
        want.hit_total        = sample_count;
        want.sum_of_intervals = interval_total;
        if (int'(req.rank) < tkls_pkg::LIST_DEPTH) begin
          want.largest_at_rank  = top_values[req.rank];
          want.smallest_at_rank = bottom_values[req.rank];
        end else begin
          want.largest_at_rank  = '0;
          want.smallest_at_rank = tkls_pkg::ALL_ONES;
        end
        want.interval_taken = took;
        expected_words = {expected_words, want};
      end
    end
    pending = expected_words.size();
  end

endmodule

// ----- tb/top_k_latency_statistics_test.sv -----
`timescale 1ns / 100ps

module top_k_latency_statistics_test;

  // Unused function code; the block must treat it as a read
  localparam logic [tkls_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int RANDOM_WORDS = 625;
  localparam int QUIET_TAIL   = 80;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   stall_left = 0;
  logic [tkls_pkg::WORD_W-1:0] stamp_cursor;

  tkls_req_if req_ch ();
  tkls_rsp_if rsp_ch ();

  top_k_latency_statistics dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  tkls_stats_checker stats_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // Stall the response side in random bursts
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        stall_left <= int'($urandom_range(1, 16));
    end
  end

  // Offer one request word, hold it until accepted, then maybe idle
  task automatic issue(input logic [tkls_pkg::FUNC_W-1:0] f,
                       input logic [tkls_pkg::WORD_W-1:0] s,
                       input logic [tkls_pkg::RANK_W-1:0] r);
    req_ch.valid  <= 1'b1;
    req_ch.func   <= f;
    req_ch.sample <= s;
    req_ch.rank   <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 35;
      default: return 70;
    endcase
  endfunction

  initial begin
    int                          n;
    int                          k;
    int                          sel;
    logic [tkls_pkg::FUNC_W-1:0] f;
    logic [tkls_pkg::WORD_W-1:0] s;

    req_ch.valid  = 1'b0;
    req_ch.func   = tkls_pkg::FUNC_READ;
    req_ch.sample = '0;
    req_ch.rank   = '0;
    rst           = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty lists, stamp sequencing, extremes, ties, spare code
    idle_pct  = 20;
    stall_pct = 20;
    issue(tkls_pkg::FUNC_READ, '0, 3'd0);
    issue(tkls_pkg::FUNC_READ, tkls_pkg::ALL_ONES, 3'd7);
    issue(tkls_pkg::FUNC_STAMP, 64'd1000, 3'd0);
    issue(tkls_pkg::FUNC_STAMP, 64'd1500, 3'd0);
    issue(tkls_pkg::FUNC_STAMP, 64'd100, 3'd1);
    issue(tkls_pkg::FUNC_STAMP, tkls_pkg::ALL_ONES, 3'd2);
    issue(tkls_pkg::FUNC_STAMP, 64'd42, 3'd3);
    issue(tkls_pkg::FUNC_DURATION, '0, 3'd0);
    issue(tkls_pkg::FUNC_DURATION, tkls_pkg::ALL_ONES, 3'd0);
    issue(tkls_pkg::FUNC_DURATION, 64'd500, 3'd4);
    issue(tkls_pkg::FUNC_DURATION, 64'd500, 3'd5);
    issue(FUNC_SPARE, 64'h5555_5555_5555_5555, 3'd6);
    for (k = 0; k < 8; k++)
      issue(tkls_pkg::FUNC_DURATION, 64'(k * 7), 3'(7 - k));
    issue(tkls_pkg::FUNC_READ, 64'hAAAA_AAAA_AAAA_AAAA, 3'd7);
    issue(tkls_pkg::FUNC_READ, '0, 3'd1);
    issue(tkls_pkg::FUNC_READ, '0, 3'd6);
    issue(FUNC_SPARE, tkls_pkg::ALL_ONES, 3'd0);

    // Random: stamp runs with occasional breaks, mixed durations, reads and spare codes
    stamp_cursor = {$urandom, $urandom};
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) begin
        idle_pct  = pick_pct();
        stall_pct = pick_pct();
      end
      if (n >= RANDOM_WORDS - QUIET_TAIL) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        f = tkls_pkg::FUNC_DURATION;
        case ($urandom_range(0, 3))
          0:       s = {$urandom, $urandom};
          1:       s = 64'($urandom_range(0, 40));
          2:       s = tkls_pkg::ALL_ONES - 64'($urandom_range(0, 40));
          default: s = 64'($urandom_range(0, 1_000_000));
        endcase
      end else if (sel < 80) begin
        f = tkls_pkg::FUNC_STAMP;
        case ($urandom_range(0, 15))
          0:       s = tkls_pkg::ALL_ONES;
          1:       s = {$urandom, $urandom};
          2:       s = stamp_cursor - 64'($urandom_range(1, 5000));
          default: s = stamp_cursor + 64'($urandom_range(0, 5000));
        endcase
        stamp_cursor = s;
      end else if (sel < 95) begin
        f = tkls_pkg::FUNC_READ;
        s = {$urandom, $urandom};
      end else begin
        f = FUNC_SPARE;
        s = {$urandom, $urandom};
      end
      issue(f, s, 3'($urandom_range(0, 7)));
    end

    // Drain and give the verdict
    req_ch.valid <= 1'b0;
    stall_pct = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (12) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Give up on a hung handshake
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- top_k_latency_statistics.f -----
rtl/tkls_pkg.sv
rtl/tkls_req_if.sv
rtl/tkls_rsp_if.sv
rtl/tkls_cell.sv
rtl/top_k_latency_statistics.sv
tb/tkls_stats_checker.sv
tb/top_k_latency_statistics_test.sv
